// ----- rtl/rpop_pkg.sv -----
// ----------------------------------------------------------------------------
// rpop_pkg
// Shared types and constants for the polygon outline rasterizer.
// ----------------------------------------------------------------------------
package rpop_pkg;

   localparam int COORD_BITS_DEF     = 14;
   localparam int TRIG_FRAC_BITS_DEF = 15;

   localparam int WIDTH_BITS  = 13;
   localparam int HEIGHT_BITS = 13;
   localparam int SIDES_BITS  = 9;
   localparam int RADIUS_BITS = 12;
   localparam int ANGLE_BITS  = 9;
   localparam int ADDR_BITS   = 4;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 13'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 13'd480;
   localparam logic [SIDES_BITS-1:0]  SIDES_RST  = 9'd3;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RST = 12'd100;

   localparam logic [ANGLE_BITS-1:0] FULL_TURN = 9'd360;
   localparam logic [ANGLE_BITS-1:0] QUARTER   = 9'd90;
   localparam logic [ANGLE_BITS-1:0] HALF_TURN = 9'd180;
   localparam logic [ANGLE_BITS-1:0] THREE_Q   = 9'd270;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_SIDES  = 2'd2,
      REG_RADIUS = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
      logic [SIDES_BITS-1:0]  sides;
      logic [RADIUS_BITS-1:0] radius;
   } cfg_type;

   typedef struct packed {
      logic div_init;
      logic div_step;
      logic set_step;
      logic mul;
      logic tgt;
      logic copy;
      logic adv;
      logic walk;
      logic idle_out;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic at_tgt;
      logic closing;
   } status_type;

endpackage

// ----- rtl/regular_polygon_outline_pixels_top.sv -----
// ----------------------------------------------------------------------------
// regular_polygon_outline_pixels_top
// Regular polygon outline rasterizer with APB-style register port.
// ----------------------------------------------------------------------------
// Each request (req_start_req) yields exactly one response. start_req = 1
// places the vertices and returns the first outline pixel; start_req = 0
// returns the next pixel. rsp_pixel_valid = 0 marks a tick with no pixel
// (idle, or the outline finished). rsp_last_pixel flags the closing pixel.
// A walk step runs the check and emit states; each vertex crossed adds the
// advance, multiply, sum and check states. A start request first runs the
// serial 360/n divider and then places the first two vertices.
// Requests are taken one at a time; the next request is taken while a
// response still waits in the output register.
// A stalled response holds its payload; the block then waits before
// loading the next result. Reset clears the walk and loads the register
// defaults 640, 480, 3, 100. Registers: width 0x0, height 0x4,
// sides 0x8, radius 0xC; write only while the block is idle.
// ----------------------------------------------------------------------------
module regular_polygon_outline_pixels_top
   import rpop_pkg::*;
#(
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_start_req,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_pixel_valid,
   output logic signed [COORD_BITS-1:0] rsp_pixel_col,
   output logic signed [COORD_BITS-1:0] rsp_pixel_row,
   output logic                         rsp_in_frame,
   output logic                         rsp_last_pixel,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ADDR_BITS-1:0]         csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   cfg_type       cfg_ff;
   cmd_type       cmd;
   status_type    status;
   reg_index_type idx;
   logic          wr;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[3:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= WIDTH_RST;
         cfg_ff.height <= HEIGHT_RST;
         cfg_ff.sides  <= SIDES_RST;
         cfg_ff.radius <= RADIUS_RST;
      end else if (wr) begin
         unique case (idx)
            REG_WIDTH:  cfg_ff.width  <= csr_pwdata[WIDTH_BITS-1:0];
            REG_HEIGHT: cfg_ff.height <= csr_pwdata[HEIGHT_BITS-1:0];
            REG_SIDES:  cfg_ff.sides  <= csr_pwdata[SIDES_BITS-1:0];
            REG_RADIUS: cfg_ff.radius <= csr_pwdata[RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_WIDTH:  csr_prdata = 32'(cfg_ff.width);
         REG_HEIGHT: csr_prdata = 32'(cfg_ff.height);
         REG_SIDES:  csr_prdata = 32'(cfg_ff.sides);
         REG_RADIUS: csr_prdata = 32'(cfg_ff.radius);
         default:    csr_prdata = '0;
      endcase
   end

   rpop_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   rpop_dp #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .status       (status),
      .pix_valid    (rsp_pixel_valid),
      .pix_col      (rsp_pixel_col),
      .pix_row      (rsp_pixel_row),
      .pix_in_frame (rsp_in_frame),
      .pix_last     (rsp_last_pixel)
   );

endmodule

// ----- rtl/rpop_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpop_ctrl
// Sequencer: request intake, vertex setup, walk and result hand-off.
// ----------------------------------------------------------------------------
module rpop_ctrl
   import rpop_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_start_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_T0M, S_T0T, S_COPY, S_ADV, S_TM, S_TT,
      S_CHECK, S_EMIT_PIX, S_EMIT_NONE
   } state_type;

   state_type state_ff, state_in;
   logic      drawing_ff, drawing_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      drawing_in   = drawing_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_start_req) begin
                  cmd.div_init = 1'b1;
                  state_in     = S_DIV;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.set_step = 1'b1;
               state_in     = S_T0M;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_T0M: begin
            cmd.mul  = 1'b1;
            state_in = S_T0T;
         end
         S_T0T: begin
            cmd.tgt  = 1'b1;
            state_in = S_COPY;
         end
         S_COPY: begin
            cmd.copy   = 1'b1;
            drawing_in = 1'b1;
            state_in   = S_ADV;
         end
         S_ADV: begin
            cmd.adv  = 1'b1;
            state_in = S_TM;
         end
         S_TM: begin
            cmd.mul  = 1'b1;
            state_in = S_TT;
         end
         S_TT: begin
            cmd.tgt  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (!drawing_ff) begin
               state_in = S_EMIT_NONE;
            end else if (status.at_tgt && status.closing) begin
               drawing_in = 1'b0;
               state_in   = S_EMIT_NONE;
            end else if (status.at_tgt) begin
               state_in = S_ADV;
            end else begin
               state_in = S_EMIT_PIX;
            end
         end
         S_EMIT_PIX: begin
            if (out_free) begin
               cmd.walk     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT_NONE: begin
            if (out_free) begin
               cmd.idle_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         drawing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drawing_ff   <= drawing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/rpop_dp.sv -----
// ----------------------------------------------------------------------------
// rpop_dp
// Datapath: step divider, trig table, vertex multiply, pixel walk, result.
// ----------------------------------------------------------------------------
module rpop_dp
   import rpop_pkg::*;
#(
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  cmd_type                      cmd,
   output status_type                   status,
   output logic                         pix_valid,
   output logic signed [COORD_BITS-1:0] pix_col,
   output logic signed [COORD_BITS-1:0] pix_row,
   output logic                         pix_in_frame,
   output logic                         pix_last
);

   localparam int F  = TRIG_FRAC_BITS;
   localparam int SW = F + 2;
   localparam int PW = RADIUS_BITS + 1 + SW;
   localparam int TW = PW + 1;
   localparam int CW = ((COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS) + 1;

   typedef logic [90:0][F:0] sin_tab_type;

   // elaboration-time long division for the table build
   function automatic longint unsigned udiv_const(input longint unsigned n,
                                                  input longint unsigned d);
      longint unsigned qv;
      longint unsigned rv;
      qv = '0;
      rv = '0;
      for (int b = 63; b >= 0; b--) begin
         rv = {rv[62:0], n[b]};
         if (rv >= d) begin
            rv    = rv - d;
            qv[b] = 1'b1;
         end
      end
      return qv;
   endfunction

   function automatic sin_tab_type build_sin();
      sin_tab_type       tab;
      longint unsigned   x;
      longint unsigned   term;
      longint            sum;
      longint            q;
      tab = '0;
      for (int k = 0; k <= 90; k++) begin
         x    = udiv_const(longint'(k) * PI_Q30, 64'd180);
         term = x;
         sum  = longint'(x);
         for (int i = 1; i <= 13; i++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = udiv_const(term, longint'((2 * i) * (2 * i + 1)));
            if (i[0]) sum = sum - longint'(term);
            else      sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         q = (sum + (longint'(1) << (29 - F))) >>> (30 - F);
         if (q > (longint'(1) << F)) q = longint'(1) << F;
         tab[k] = q[F:0];
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin();

   function automatic logic signed [SW-1:0] sin_of(input logic [ANGLE_BITS-1:0] a);
      logic [ANGLE_BITS-1:0] idx;
      logic                  neg;
      priority if (a <= QUARTER) begin
         idx = a;
         neg = 1'b0;
      end else if (a <= HALF_TURN) begin
         idx = HALF_TURN - a;
         neg = 1'b0;
      end else if (a <= THREE_Q) begin
         idx = a - HALF_TURN;
         neg = 1'b1;
      end else begin
         idx = FULL_TURN - a;
         neg = 1'b1;
      end
      if (neg) return -$signed({1'b0, SIN_TAB[idx[6:0]]});
      else     return  $signed({1'b0, SIN_TAB[idx[6:0]]});
   endfunction

   function automatic logic signed [COORD_BITS-1:0] to_coord(input logic signed [TW-1:0] t);
      logic signed [TW-1:0] adj;
      logic signed [TW-1:0] sh;
      adj = t[TW-1] ? t + TW'((1 << F) - 1) : t;
      sh  = adj >>> F;
      return sh[COORD_BITS-1:0];
   endfunction

   function automatic logic signed [COORD_BITS-1:0] toward(
      input logic signed [COORD_BITS-1:0] v,
      input logic signed [COORD_BITS-1:0] t);
      priority if (v < t) return v + COORD_BITS'(1);
      else if (v > t)     return v - COORD_BITS'(1);
      else                return v;
   endfunction

   logic [ANGLE_BITS-1:0]        dvd_ff, quo_ff, rem_ff;
   logic [3:0]                   cnt_ff;
   logic [ANGLE_BITS:0]          rem_sh;
   logic [SIDES_BITS-1:0]        sides_eff;
   logic [ANGLE_BITS-1:0]        step_ff, angle_ff, vc_ff;
   logic [ANGLE_BITS-1:0]        vc_in, a_mod;
   logic [ANGLE_BITS:0]          a_cos;
   logic [ANGLE_BITS-1:0]        a_cos_m;
   logic signed [PW-1:0]         prod_c_ff, prod_s_ff;
   logic signed [COORD_BITS-1:0] cur_col_ff, cur_row_ff, tgt_col_ff, tgt_row_ff;
   logic signed [COORD_BITS-1:0] nxt_col, nxt_row;
   logic signed [TW-1:0]         cx_q, cy_q;
   logic signed [CW-1:0]         col_x, row_x, w_x, h_x;
   logic                         in_frm;

   assign sides_eff = (cfg.sides == '0) ? SIDES_BITS'(1) : cfg.sides;
   assign rem_sh    = {rem_ff, dvd_ff[ANGLE_BITS-1]};
   assign vc_in     = vc_ff + ANGLE_BITS'(1);

   assign a_mod   = (angle_ff >= FULL_TURN) ? angle_ff - FULL_TURN : angle_ff;
   assign a_cos   = {1'b0, a_mod} + {1'b0, QUARTER};
   assign a_cos_m = (a_cos >= {1'b0, FULL_TURN}) ? ANGLE_BITS'(a_cos - {1'b0, FULL_TURN})
                                                 : a_cos[ANGLE_BITS-1:0];

   assign cx_q = $signed(TW'({1'b0, cfg.width[WIDTH_BITS-1:1]}) << F);
   assign cy_q = $signed(TW'({1'b0, cfg.height[HEIGHT_BITS-1:1]}) << F);

   assign nxt_col = toward(cur_col_ff, tgt_col_ff);
   assign nxt_row = toward(cur_row_ff, tgt_row_ff);

   assign col_x  = CW'(cur_col_ff);
   assign row_x  = CW'(cur_row_ff);
   assign w_x    = $signed(CW'(cfg.width));
   assign h_x    = $signed(CW'(cfg.height));
   assign in_frm = !col_x[CW-1] && (col_x < w_x) && !row_x[CW-1] && (row_x < h_x);

   assign status.div_done = (cnt_ff == '0);
   assign status.at_tgt   = (cur_col_ff == tgt_col_ff) && (cur_row_ff == tgt_row_ff);
   assign status.closing  = (vc_ff >= sides_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_init) begin
         cnt_ff <= 4'(ANGLE_BITS);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dvd_ff <= FULL_TURN;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[ANGLE_BITS-2:0], 1'b0};
         if (rem_sh >= {1'b0, sides_eff}) begin
            rem_ff <= ANGLE_BITS'(rem_sh - {1'b0, sides_eff});
            quo_ff <= {quo_ff[ANGLE_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[ANGLE_BITS-1:0];
            quo_ff <= {quo_ff[ANGLE_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         angle_ff <= '0;
         vc_ff    <= '0;
      end else if (cmd.set_step) begin
         step_ff  <= quo_ff;
         angle_ff <= '0;
         vc_ff    <= '0;
      end else if (cmd.adv) begin
         vc_ff    <= vc_in;
         angle_ff <= (vc_in >= sides_eff) ? '0 : angle_ff + step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_c_ff <= $signed({1'b0, cfg.radius}) * sin_of(a_cos_m);
         prod_s_ff <= $signed({1'b0, cfg.radius}) * sin_of(a_mod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_col_ff <= '0;
         tgt_row_ff <= '0;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else begin
         if (cmd.tgt) begin
            tgt_col_ff <= to_coord(cx_q + TW'(prod_c_ff));
            tgt_row_ff <= to_coord(cy_q - TW'(prod_s_ff));
         end
         if (cmd.copy) begin
            cur_col_ff <= tgt_col_ff;
            cur_row_ff <= tgt_row_ff;
         end else if (cmd.walk) begin
            cur_col_ff <= nxt_col;
            cur_row_ff <= nxt_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk) begin
         pix_valid    <= 1'b1;
         pix_col      <= cur_col_ff;
         pix_row      <= cur_row_ff;
         pix_in_frame <= in_frm;
         pix_last     <= (nxt_col == tgt_col_ff) && (nxt_row == tgt_row_ff) &&
                         status.closing;
      end else if (cmd.idle_out) begin
         pix_valid    <= 1'b0;
         pix_col      <= '0;
         pix_row      <= '0;
         pix_in_frame <= 1'b0;
         pix_last     <= 1'b0;
      end
   end

endmodule

// ----- rtl/rpop_checker.sv -----
// ----------------------------------------------------------------------------
// rpop_checker
// Port-level checks for the polygon outline rasterizer.
// ----------------------------------------------------------------------------
module rpop_checker
   import rpop_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_pixel_valid,
   input logic [COORD_BITS-1:0] rsp_pixel_col,
   input logic                  rsp_in_frame,
   input logic                  rsp_last_pixel
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_no_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |->
         rsp_pixel_col == '0 && !rsp_in_frame && !rsp_last_pixel)
      else $error("empty tick carries payload");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while one is in progress");

endmodule

bind regular_polygon_outline_pixels_top rpop_checker #(
   .COORD_BITS (COORD_BITS)
) u_rpop_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_valid (rsp_pixel_valid),
   .rsp_pixel_col   (rsp_pixel_col),
   .rsp_in_frame    (rsp_in_frame),
   .rsp_last_pixel  (rsp_last_pixel)
);
